[hw/rtl/tpo2d_pkg.sv]
package tpo2d_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int NUM_PTS     = 6;
  localparam int NUM_TRI     = 20;

  typedef logic [2:0] pidx_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
  } pt_t;

  typedef struct packed {
    logic pos;
    logic neg;
  } sgn_t;

  typedef sgn_t [NUM_PTS-1:0][NUM_PTS-1:0][NUM_PTS-1:0] ord_tab_t;

  // point order: A0 A1 A2 B0 B1 B2; all unordered triples, ascending
  localparam pidx_t TRI_A [NUM_TRI] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3};
  localparam pidx_t TRI_B [NUM_TRI] = '{
    3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4,
    3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd4, 3'd4};
  localparam pidx_t TRI_C [NUM_TRI] = '{
    3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5, 3'd5,
    3'd3, 3'd4, 3'd5, 3'd4, 3'd5, 3'd5, 3'd4, 3'd5, 3'd5, 3'd5};

  localparam pidx_t IDX_A0 = 3'd0;
  localparam pidx_t IDX_A1 = 3'd1;
  localparam pidx_t IDX_A2 = 3'd2;
  localparam pidx_t IDX_B0 = 3'd3;
  localparam pidx_t IDX_B1 = 3'd4;
  localparam pidx_t IDX_B2 = 3'd5;

  function automatic logic ge(ord_tab_t t, pidx_t a, pidx_t b, pidx_t c);
    return !t[a][b][c].neg;
  endfunction

  function automatic logic le(ord_tab_t t, pidx_t a, pidx_t b, pidx_t c);
    return !t[a][b][c].pos;
  endfunction

  function automatic logic gt(ord_tab_t t, pidx_t a, pidx_t b, pidx_t c);
    return t[a][b][c].pos;
  endfunction

  function automatic logic vertex_case(ord_tab_t t, pidx_t p1, pidx_t q1, pidx_t r1,
                                       pidx_t p2, pidx_t q2, pidx_t r2);
    if (ge(t, r2, p2, q1)) begin
      if (le(t, r2, q2, q1)) begin
        if (gt(t, p1, p2, q1))
          return le(t, p1, q2, q1);
        return ge(t, p1, p2, r1) && ge(t, q1, r1, p2);
      end
      return le(t, p1, q2, q1) && le(t, r2, q2, r1) && ge(t, q1, r1, q2);
    end
    if (ge(t, r2, p2, r1)) begin
      if (ge(t, q1, r1, r2))
        return ge(t, p1, p2, r1);
      return ge(t, q1, r1, q2) && ge(t, r2, r1, q2);
    end
    return 1'b0;
  endfunction

  function automatic logic edge_case(ord_tab_t t, pidx_t p1, pidx_t q1, pidx_t r1,
                                     pidx_t p2, pidx_t r2);
    if (ge(t, r2, p2, q1)) begin
      if (ge(t, p1, p2, q1))
        return ge(t, p1, q1, r2);
      return ge(t, q1, r1, p2) && ge(t, r1, p1, p2);
    end
    if (ge(t, r2, p2, r1))
      return ge(t, p1, p2, r1) && (ge(t, p1, r1, r2) || ge(t, q1, r1, r2));
    return 1'b0;
  endfunction

  function automatic logic ccw_pair(ord_tab_t t, pidx_t p1, pidx_t q1, pidx_t r1,
                                    pidx_t p2, pidx_t q2, pidx_t r2);
    if (ge(t, p2, q2, p1)) begin
      if (ge(t, q2, r2, p1))
        return ge(t, r2, p2, p1) || edge_case(t, p1, q1, r1, p2, r2);
      if (ge(t, r2, p2, p1))
        return edge_case(t, p1, q1, r1, r2, q2);
      return vertex_case(t, p1, q1, r1, p2, q2, r2);
    end
    if (ge(t, q2, r2, p1)) begin
      if (ge(t, r2, p2, p1))
        return edge_case(t, p1, q1, r1, q2, p2);
      return vertex_case(t, p1, q1, r1, q2, r2, p2);
    end
    return vertex_case(t, p1, q1, r1, r2, p2, q2);
  endfunction

endpackage

[hw/rtl/triangle_pair_overlap_2d_top.sv]
// Triangle pair overlap test, 2D, closed triangles (boundary counts).
// Input: a pair is transferred at a rising edge with start high and busy low.
// busy is always low, so one pair can be transferred every cycle.
// Output: done is high for one cycle per pair with overlapping valid; the
// transfer completes at the edge ending that cycle. There is no backpressure.
// Pipeline: done rises after the pair has passed three register stages
// plus the result register:
//   stage 1 latches the coordinates,
//   stage 2 latches both products of all 20 orientation determinants,
//   stage 3 latches the sign of each determinant,
//   result register evaluates the decision tree on the signs, with the
//   clockwise-to-counterclockwise vertex swap folded into the lookup.
// Throughput: one pair per cycle, set by the fully pipelined product stage.
// Reset (rst, synchronous): clears the stage valid flags; any pair in
// flight is dropped and done stays low until a new pair comes through.
module triangle_pair_overlap_2d_top
  import tpo2d_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] tri_a_p0_x,
  input  logic signed [COORD_WIDTH-1:0] tri_a_p0_y,
  input  logic signed [COORD_WIDTH-1:0] tri_a_p1_x,
  input  logic signed [COORD_WIDTH-1:0] tri_a_p1_y,
  input  logic signed [COORD_WIDTH-1:0] tri_a_p2_x,
  input  logic signed [COORD_WIDTH-1:0] tri_a_p2_y,
  input  logic signed [COORD_WIDTH-1:0] tri_b_p0_x,
  input  logic signed [COORD_WIDTH-1:0] tri_b_p0_y,
  input  logic signed [COORD_WIDTH-1:0] tri_b_p1_x,
  input  logic signed [COORD_WIDTH-1:0] tri_b_p1_y,
  input  logic signed [COORD_WIDTH-1:0] tri_b_p2_x,
  input  logic signed [COORD_WIDTH-1:0] tri_b_p2_y,
  output logic                          done,
  output logic                          overlapping
);

  pt_t                         pts [NUM_PTS];
  logic                        vld1;
  logic signed [PROD_WIDTH-1:0] prod_l      [NUM_TRI];
  logic signed [PROD_WIDTH-1:0] prod_r      [NUM_TRI];
  logic signed [PROD_WIDTH-1:0] prod_l_next [NUM_TRI];
  logic signed [PROD_WIDTH-1:0] prod_r_next [NUM_TRI];
  logic                        vld2;
  sgn_t                        sgn [NUM_TRI];
  logic                        vld3;
  ord_tab_t                    ord;
  pidx_t                       q1, r1, q2, r2;
  logic                        overlapping_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      done <= 1'b0;
    end else begin
      vld1 <= start & ~busy;
      vld2 <= vld1;
      vld3 <= vld2;
      done <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      pts[0] <= '{x: tri_a_p0_x, y: tri_a_p0_y};
      pts[1] <= '{x: tri_a_p1_x, y: tri_a_p1_y};
      pts[2] <= '{x: tri_a_p2_x, y: tri_a_p2_y};
      pts[3] <= '{x: tri_b_p0_x, y: tri_b_p0_y};
      pts[4] <= '{x: tri_b_p1_x, y: tri_b_p1_y};
      pts[5] <= '{x: tri_b_p2_x, y: tri_b_p2_y};
    end
  end

  // (a-c)x*(b-c)y and (a-c)y*(b-c)x for each triple
  always_comb begin
    logic signed [DIFF_WIDTH-1:0] acx, acy, bcx, bcy;
    for (int t = 0; t < NUM_TRI; t++) begin
      acx = DIFF_WIDTH'(pts[TRI_A[t]].x) - DIFF_WIDTH'(pts[TRI_C[t]].x);
      acy = DIFF_WIDTH'(pts[TRI_A[t]].y) - DIFF_WIDTH'(pts[TRI_C[t]].y);
      bcx = DIFF_WIDTH'(pts[TRI_B[t]].x) - DIFF_WIDTH'(pts[TRI_C[t]].x);
      bcy = DIFF_WIDTH'(pts[TRI_B[t]].y) - DIFF_WIDTH'(pts[TRI_C[t]].y);
      prod_l_next[t] = acx * bcy;
      prod_r_next[t] = acy * bcx;
    end
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < NUM_TRI; t++) begin
      prod_l[t] <= prod_l_next[t];
      prod_r[t] <= prod_r_next[t];
      sgn[t]    <= '{pos: prod_l[t] > prod_r[t], neg: prod_l[t] < prod_r[t]};
    end
  end

  // expand to every ordered triple; odd permutations flip the sign
  always_comb begin
    ord = '0;
    for (int i = 0; i < NUM_PTS; i++) begin
      for (int j = 0; j < NUM_PTS; j++) begin
        for (int k = 0; k < NUM_PTS; k++) begin
          for (int t = 0; t < NUM_TRI; t++) begin
            if ((TRI_A[t] == pidx_t'(i) && TRI_B[t] == pidx_t'(j) && TRI_C[t] == pidx_t'(k)) ||
                (TRI_A[t] == pidx_t'(j) && TRI_B[t] == pidx_t'(k) && TRI_C[t] == pidx_t'(i)) ||
                (TRI_A[t] == pidx_t'(k) && TRI_B[t] == pidx_t'(i) && TRI_C[t] == pidx_t'(j)))
              ord[i][j][k] = sgn[t];
            if ((TRI_A[t] == pidx_t'(j) && TRI_B[t] == pidx_t'(i) && TRI_C[t] == pidx_t'(k)) ||
                (TRI_A[t] == pidx_t'(i) && TRI_B[t] == pidx_t'(k) && TRI_C[t] == pidx_t'(j)) ||
                (TRI_A[t] == pidx_t'(k) && TRI_B[t] == pidx_t'(j) && TRI_C[t] == pidx_t'(i)))
              ord[i][j][k] = '{pos: sgn[t].neg, neg: sgn[t].pos};
          end
        end
      end
    end
  end

  always_comb begin
    q1 = ord[IDX_A0][IDX_A1][IDX_A2].neg ? IDX_A2 : IDX_A1;
    r1 = ord[IDX_A0][IDX_A1][IDX_A2].neg ? IDX_A1 : IDX_A2;
    q2 = ord[IDX_B0][IDX_B1][IDX_B2].neg ? IDX_B2 : IDX_B1;
    r2 = ord[IDX_B0][IDX_B1][IDX_B2].neg ? IDX_B1 : IDX_B2;
    overlapping_next = ccw_pair(ord, IDX_A0, q1, r1, IDX_B0, q2, r2);
  end

  always_ff @(posedge clk) begin
    overlapping <= overlapping_next;
  end

endmodule

[verif/tpo2d_overlap_checker.sv]
module tpo2d_overlap_checker
  import tpo2d_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] tri_a_p0_x,
  input  logic signed [COORD_WIDTH-1:0] tri_a_p0_y,
  input  logic signed [COORD_WIDTH-1:0] tri_a_p1_x,
  input  logic signed [COORD_WIDTH-1:0] tri_a_p1_y,
  input  logic signed [COORD_WIDTH-1:0] tri_a_p2_x,
  input  logic signed [COORD_WIDTH-1:0] tri_a_p2_y,
  input  logic signed [COORD_WIDTH-1:0] tri_b_p0_x,
  input  logic signed [COORD_WIDTH-1:0] tri_b_p0_y,
  input  logic signed [COORD_WIDTH-1:0] tri_b_p1_x,
  input  logic signed [COORD_WIDTH-1:0] tri_b_p1_y,
  input  logic signed [COORD_WIDTH-1:0] tri_b_p2_x,
  input  logic signed [COORD_WIDTH-1:0] tri_b_p2_y,
  input  logic                          done,
  input  logic                          overlapping,
  output int                            fail_count,
  output int                            outstanding
);

  bit overlap_expected_q[$];

  // sign of (a-c)x*(b-c)y - (a-c)y*(b-c)x, exact in 64 bits
  function automatic int turn_sign(pt_t a, pt_t b, pt_t c);
    longint lhs;
    longint rhs;
    lhs = (longint'($signed(a.x)) - longint'($signed(c.x))) *
          (longint'($signed(b.y)) - longint'($signed(c.y)));
    rhs = (longint'($signed(a.y)) - longint'($signed(c.y))) *
          (longint'($signed(b.x)) - longint'($signed(c.x)));
    if (lhs > rhs) return 1;
    if (lhs < rhs) return -1;
    return 0;
  endfunction

  function automatic bit corner_test(pt_t p1, pt_t q1, pt_t r1, pt_t p2, pt_t q2, pt_t r2);
    if (turn_sign(r2, p2, q1) >= 0) begin
      if (turn_sign(r2, q2, q1) <= 0) begin
        if (turn_sign(p1, p2, q1) > 0)
          return turn_sign(p1, q2, q1) <= 0;
        return turn_sign(p1, p2, r1) >= 0 && turn_sign(q1, r1, p2) >= 0;
      end
      return turn_sign(p1, q2, q1) <= 0 && turn_sign(r2, q2, r1) <= 0 &&
             turn_sign(q1, r1, q2) >= 0;
    end
    if (turn_sign(r2, p2, r1) >= 0) begin
      if (turn_sign(q1, r1, r2) >= 0)
        return turn_sign(p1, p2, r1) >= 0;
      return turn_sign(q1, r1, q2) >= 0 && turn_sign(r2, r1, q2) >= 0;
    end
    return 1'b0;
  endfunction

  function automatic bit side_test(pt_t p1, pt_t q1, pt_t r1, pt_t p2, pt_t r2);
    if (turn_sign(r2, p2, q1) >= 0) begin
      if (turn_sign(p1, p2, q1) >= 0)
        return turn_sign(p1, q1, r2) >= 0;
      return turn_sign(q1, r1, p2) >= 0 && turn_sign(r1, p1, p2) >= 0;
    end
    if (turn_sign(r2, p2, r1) >= 0)
      return turn_sign(p1, p2, r1) >= 0 &&
             (turn_sign(p1, r1, r2) >= 0 || turn_sign(q1, r1, r2) >= 0);
    return 1'b0;
  endfunction

  // both triangles counter-clockwise; locate p1 against the edges of the second
  function automatic bit ordered_overlap(pt_t p1, pt_t q1, pt_t r1,
                                         pt_t p2, pt_t q2, pt_t r2);
    if (turn_sign(p2, q2, p1) >= 0) begin
      if (turn_sign(q2, r2, p1) >= 0)
        return turn_sign(r2, p2, p1) >= 0 || side_test(p1, q1, r1, p2, r2);
      if (turn_sign(r2, p2, p1) >= 0)
        return side_test(p1, q1, r1, r2, q2);
      return corner_test(p1, q1, r1, p2, q2, r2);
    end
    if (turn_sign(q2, r2, p1) >= 0) begin
      if (turn_sign(r2, p2, p1) >= 0)
        return side_test(p1, q1, r1, q2, p2);
      return corner_test(p1, q1, r1, q2, r2, p2);
    end
    return corner_test(p1, q1, r1, r2, p2, q2);
  endfunction

  function automatic bit predict_overlap(pt_t a0, pt_t a1, pt_t a2,
                                         pt_t b0, pt_t b1, pt_t b2);
    pt_t t;
    if (turn_sign(a0, a1, a2) < 0) begin
      t  = a1;
      a1 = a2;
      a2 = t;
    end
    if (turn_sign(b0, b1, b2) < 0) begin
      t  = b1;
      b1 = b2;
      b2 = t;
    end
    return ordered_overlap(a0, a1, a2, b0, b1, b2);
  endfunction

  always @(posedge clk) begin
    bit want;
    if (rst) begin
      overlap_expected_q.delete();
    end else begin
      if (done) begin
        if (overlap_expected_q.size() == 0) begin
          $display("%0t: unexpected overlap result: expected none, actual %0b",
                   $time, overlapping);
          fail_count++;
        end else begin
          want = overlap_expected_q.pop_front();
          if (overlapping !== want) begin
            $display("%0t: overlapping mismatch: expected %0b, actual %0b",
                     $time, want, overlapping);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        overlap_expected_q.push_back(predict_overlap(
          pt_t'{x: tri_a_p0_x, y: tri_a_p0_y},
          pt_t'{x: tri_a_p1_x, y: tri_a_p1_y},
          pt_t'{x: tri_a_p2_x, y: tri_a_p2_y},
          pt_t'{x: tri_b_p0_x, y: tri_b_p0_y},
          pt_t'{x: tri_b_p1_x, y: tri_b_p1_y},
          pt_t'{x: tri_b_p2_x, y: tri_b_p2_y}));
    end
    outstanding <= overlap_expected_q.size();
  end

endmodule

[verif/triangle_pair_overlap_2d_top_tb.sv]
module triangle_pair_overlap_2d_top_tb
  import tpo2d_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PAIRS   = 1280;
  localparam int CALM_PAIRS     = 200;

  typedef int coord_set_t [12];

  typedef enum int {
    SHAPE_WIDE,
    SHAPE_TIGHT,
    SHAPE_SHARED,
    SHAPE_FLAT,
    SHAPE_EXTREME,
    SHAPE_SCALED
  } shape_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic signed [COORD_WIDTH-1:0] tri_a_p0_x;
  logic signed [COORD_WIDTH-1:0] tri_a_p0_y;
  logic signed [COORD_WIDTH-1:0] tri_a_p1_x;
  logic signed [COORD_WIDTH-1:0] tri_a_p1_y;
  logic signed [COORD_WIDTH-1:0] tri_a_p2_x;
  logic signed [COORD_WIDTH-1:0] tri_a_p2_y;
  logic signed [COORD_WIDTH-1:0] tri_b_p0_x;
  logic signed [COORD_WIDTH-1:0] tri_b_p0_y;
  logic signed [COORD_WIDTH-1:0] tri_b_p1_x;
  logic signed [COORD_WIDTH-1:0] tri_b_p1_y;
  logic signed [COORD_WIDTH-1:0] tri_b_p2_x;
  logic signed [COORD_WIDTH-1:0] tri_b_p2_y;
  logic                          done;
  logic                          overlapping;
  int                            fail_count;
  int                            outstanding;
  int                            quiet_cycles;

  triangle_pair_overlap_2d_top dut (.*);

  tpo2d_overlap_checker overlap_chk (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int rand_coord();
    logic [COORD_WIDTH-1:0] r;
    r = COORD_WIDTH'($urandom);
    return int'($signed(r));
  endfunction

  function automatic int clamp_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int near(int base, int span);
    return clamp_coord(base + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic put_coords(coord_set_t c);
    tri_a_p0_x <= COORD_WIDTH'(c[0]);
    tri_a_p0_y <= COORD_WIDTH'(c[1]);
    tri_a_p1_x <= COORD_WIDTH'(c[2]);
    tri_a_p1_y <= COORD_WIDTH'(c[3]);
    tri_a_p2_x <= COORD_WIDTH'(c[4]);
    tri_a_p2_y <= COORD_WIDTH'(c[5]);
    tri_b_p0_x <= COORD_WIDTH'(c[6]);
    tri_b_p0_y <= COORD_WIDTH'(c[7]);
    tri_b_p1_x <= COORD_WIDTH'(c[8]);
    tri_b_p1_y <= COORD_WIDTH'(c[9]);
    tri_b_p2_x <= COORD_WIDTH'(c[10]);
    tri_b_p2_y <= COORD_WIDTH'(c[11]);
  endtask

  // optional idle burst with junk on the coordinates, then one transfer
  task automatic send_pair(coord_set_t c, bit idle_ok);
    coord_set_t junk;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      foreach (junk[i]) junk[i] = rand_coord();
      start <= 1'b0;
      put_coords(junk);
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start <= 1'b1;
    put_coords(c);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic make_pair(output coord_set_t c);
    int     extreme_vals [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    int     bx;
    int     by;
    int     dx;
    int     dy;
    int     k;
    int     span;
    shape_t shape;
    shape = shape_t'($urandom_range(0, 5));
    bx    = rand_coord();
    by    = rand_coord();
    case (shape)
      SHAPE_WIDE: begin
        foreach (c[i]) c[i] = rand_coord();
      end
      SHAPE_TIGHT: begin
        foreach (c[i]) c[i] = near((i % 2) ? by : bx, 4);
      end
      SHAPE_SHARED: begin
        foreach (c[i]) c[i] = near((i % 2) ? by : bx, 32);
        for (int j = 3; j < 6; j++) begin
          if ($urandom_range(0, 1) == 1) begin
            k = $urandom_range(0, 2);
            c[2*j]   = c[2*k];
            c[2*j+1] = c[2*k+1];
          end
        end
      end
      SHAPE_FLAT: begin
        foreach (c[i]) c[i] = near((i % 2) ? by : bx, 10);
        dx = int'($urandom_range(0, 10)) - 5;
        dy = int'($urandom_range(0, 10)) - 5;
        for (int j = 0; j < 3; j++) begin
          k = int'($urandom_range(0, 6)) - 3;
          c[2*j]   = clamp_coord(bx + k * dx);
          c[2*j+1] = clamp_coord(by + k * dy);
        end
        if ($urandom_range(0, 1) == 1) begin
          for (int j = 3; j < 6; j++) begin
            k = int'($urandom_range(0, 6)) - 3;
            c[2*j]   = clamp_coord(bx + 1 + k * dy);
            c[2*j+1] = clamp_coord(by + k * dx);
          end
        end
      end
      SHAPE_EXTREME: begin
        foreach (c[i]) c[i] = extreme_vals[$urandom_range(0, 6)];
      end
      default: begin
        span = 1 << $urandom_range(1, 15);
        foreach (c[i]) c[i] = near((i % 2) ? by : bx, span);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    coord_set_t pair;
    foreach (pair[i]) pair[i] = 0;
    rst   <= 1'b1;
    start <= 1'b0;
    put_coords(pair);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_pair('{0, 0, 100, 0, 0, 100, 0, 0, 100, 0, 0, 100}, 1'b1);
    send_pair('{0, 0, 100, 0, 0, 100, 200, 200, 300, 200, 200, 300}, 1'b1);
    send_pair('{0, 0, 0, 100, 100, 0, 100, 0, 200, 100, 200, 0}, 1'b1);
    send_pair('{0, 0, 100, 0, 0, 100, 101, 0, 200, 0, 101, 100}, 1'b1);
    send_pair('{0, 0, 100, 0, 0, 100, 100, 0, 0, 100, 100, 100}, 1'b1);
    send_pair('{0, 0, 100, 0, 0, 100, 51, 51, 200, 51, 51, 200}, 1'b1);
    send_pair('{0, 0, 100, 0, 0, 100, 50, 50, 200, 50, 50, 200}, 1'b1);
    send_pair('{10, 10, 20, 10, 10, 20, -1000, -1000, 1000, -1000, 0, 1000}, 1'b1);
    send_pair('{-1000, -1000, 1000, -1000, 0, 1000, 10, 10, 20, 10, 10, 20}, 1'b1);
    send_pair('{0, 0, 100, 0, 50, 90, 0, 60, 50, -30, 100, 60}, 1'b1);
    // collinear and coincident vertices
    send_pair('{0, 0, 50, 50, 100, 100, 100, 0, 200, 0, 0, 100}, 1'b1);
    send_pair('{0, 0, 10, 10, 20, 20, 500, 0, 600, 0, 500, 100}, 1'b1);
    send_pair('{30, 30, 30, 30, 30, 30, 0, 0, 100, 0, 0, 100}, 1'b1);
    send_pair('{50, 50, 50, 50, 50, 50, 0, 0, 100, 0, 0, 100}, 1'b1);
    send_pair('{51, 50, 51, 50, 51, 50, 0, 0, 100, 0, 0, 100}, 1'b1);
    send_pair('{0, 0, 100, 100, 50, 50, 0, 100, 100, 0, 25, 75}, 1'b1);
    send_pair('{7, -7, 7, -7, 7, -7, 7, -7, 7, -7, 7, -7}, 1'b1);
    // field extremes
    send_pair('{-32768, -32768, -32768, -32768, -32768, -32768,
                -32768, -32768, -32768, -32768, -32768, -32768}, 1'b1);
    send_pair('{32767, 32767, 32767, 32767, 32767, 32767,
                32767, 32767, 32767, 32767, 32767, 32767}, 1'b1);
    send_pair('{-32768, -32768, 32767, -32768, -32768, 32767,
                32767, 32767, -32768, 32767, 32767, -32768}, 1'b1);
    send_pair('{-32768, -32768, -32768, -32767, -32767, -32768,
                32767, 32767, 32766, 32767, 32767, 32766}, 1'b1);
    send_pair('{21845, -21846, -21846, 21845, 21845, 21845,
                -21846, -21846, 21845, -21846, -21846, 21845}, 1'b1);

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      make_pair(pair);
      send_pair(pair, n < RANDOM_PAIRS - CALM_PAIRS);
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/tpo2d_pkg.sv
hw/rtl/triangle_pair_overlap_2d_top.sv
verif/tpo2d_overlap_checker.sv
verif/triangle_pair_overlap_2d_top_tb.sv
